// ===== rtl/pm_pkg.sv =====
// ----------------------------------------------------------------------------
// Polynomial mutation package
// Widths, data types, cell coefficients and shared helper functions for the
// polynomial mutation pipeline.
// ----------------------------------------------------------------------------
package pm_pkg;

  // Fixed-point fraction bits of the internal datapath
  localparam int FRAC_BITS = 16;
  // Value in [0, 1.0] including 1.0
  localparam int QW        = FRAC_BITS + 1;
  // Normalization shift count 0..FRAC_BITS
  localparam int KW        = 5;
  // Log value k*2^FRAC_BITS - bits
  localparam int LW        = FRAC_BITS + KW;
  // Exponent in Q.4 (dist_index + 1.0)
  localparam int PW        = 13;
  // Dividend of the root exponent (log shifted up by 4)
  localparam int NW        = LW + 4;
  // Scaled exponent handed to exp2
  localparam int PV        = LW + PW - 4;

  localparam int THR_W      = 17;
  localparam int DIST_W     = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(655);
  localparam logic [DIST_W-1:0] DIST_RESET = DIST_W'(320);

  // 1.0 in Q.4, added to eta to form the exponent
  localparam logic [PW-1:0] P_BIAS = PW'(16);

  localparam logic [QW-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [QW-1:0] HALF = ONE >> 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_DIST      = 2'd1
  } cfg_idx_e;

  // Item fields that ride alongside the arithmetic cells
  typedef struct packed {
    logic [QW-1:0] gene;
    logic          mut;
    logic          last;
    logic          branch;
    logic [QW-1:0] a;
    logic [QW-1:0] b;
    logic [PW-1:0] p;
  } side_t;

  // Log cell data: mantissa, collected fraction bits, shift, zero input
  typedef struct packed {
    logic [QW-1:0]        m;
    logic [FRAC_BITS-1:0] bits;
    logic [KW-1:0]        k;
    logic                 zero;
  } lg_t;

  // Exp cell data: accumulator, remaining fraction bits, final shift
  typedef struct packed {
    logic [QW-1:0]        acc;
    logic [FRAC_BITS-1:0] f;
    logic [KW-1:0]        sh;
    logic                 zero;
  } ex_t;

  // Divider cell data
  typedef struct packed {
    logic [NW-1:0] num;
    logic [PW-1:0] rem;
    logic [NW-1:0] quo;
    logic          zero;
  } dv_t;

  // Integer square root, evaluated at elaboration only
  function automatic logic [63:0] isqrt_const(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bt;
    rem = v;
    res = '0;
    bt  = 64'h4000_0000_0000_0000;
    for (int j = 0; j < 32; j++) begin
      if (rem >= res + bt) begin
        rem = rem - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // 2^(-1/2^(idx+1)) in Q.FRAC_BITS, by repeated square roots of one half
  function automatic logic [FRAC_BITS-1:0] exp_coef(input int idx);
    logic [63:0] c;
    c = 64'(ONE >> 1);
    for (int i = 0; i <= idx; i++) begin
      c = isqrt_const(c << FRAC_BITS);
    end
    return c[FRAC_BITS-1:0];
  endfunction

  // Normalize x into [1.0, 2.0) and note the shift
  function automatic lg_t lg_init(input logic [QW-1:0] x);
    lg_t          r;
    logic [KW-1:0] k;
    k = '0;
    for (int j = 0; j < QW; j++) begin
      if (x[j]) k = KW'(FRAC_BITS - j);
    end
    r.m    = x << k;
    r.bits = '0;
    r.k    = k;
    r.zero = (x == '0);
    return r;
  endfunction

  // -log2 in Q.FRAC_BITS from a finished log chain
  function automatic logic [LW-1:0] lg_lval(input lg_t g);
    return (LW'(g.k) << FRAC_BITS) - LW'(g.bits);
  endfunction

  // Split a scaled exponent into shift and fraction for the exp chain
  function automatic ex_t ex_init(input logic zin, input logic [PV-1:0] pv);
    ex_t                      r;
    logic [PV-FRAC_BITS-1:0]  ek;
    ek     = pv[PV-1:FRAC_BITS];
    r.acc  = ONE;
    r.f    = pv[FRAC_BITS-1:0];
    r.sh   = ek[KW-1:0];
    r.zero = zin || (ek > (PV-FRAC_BITS)'(FRAC_BITS));
    return r;
  endfunction

  // Result of a finished exp chain
  function automatic logic [QW-1:0] ex_val(input ex_t e);
    return e.zero ? '0 : (e.acc >> e.sh);
  endfunction

endpackage

// ===== rtl/pm_lg_cell.sv =====
// ----------------------------------------------------------------------------
// Log cell
// One squaring step of the -log2 chain: squares the mantissa and yields one
// fraction bit of the logarithm.
// ----------------------------------------------------------------------------
module pm_lg_cell import pm_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  lg_t  lg_i,
  output lg_t  lg_o
);

  logic [2*QW-1:0] sq;
  lg_t             lg_d;
  lg_t             lg_q;

  // Square, renormalize when the square reaches 2.0
  always_comb begin
    sq   = lg_i.m * lg_i.m;
    lg_d = lg_i;
    if (sq[2*QW-1]) begin
      lg_d.m = sq[2*QW-1:FRAC_BITS+1];
    end else begin
      lg_d.m = sq[2*QW-2:FRAC_BITS];
    end
    lg_d.bits = {lg_i.bits[FRAC_BITS-2:0], sq[2*QW-1]};
  end

  // Hand to the next cell
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lg_q <= lg_d;
    end
  end

  assign lg_o = lg_q;

endmodule

// ===== rtl/pm_ex_cell.sv =====
// ----------------------------------------------------------------------------
// Exp cell
// One step of the exp2 chain: multiplies in a fixed root of one half when
// the current fraction bit is set.
// ----------------------------------------------------------------------------
module pm_ex_cell import pm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [FRAC_BITS-1:0] coef_i,
  input  ex_t                  ex_i,
  output ex_t                  ex_o
);

  logic [QW+FRAC_BITS-1:0] prod;
  ex_t                     ex_d;
  ex_t                     ex_q;

  // Scale the accumulator on a set bit, advance to the next bit
  always_comb begin
    prod = ex_i.acc * coef_i;
    ex_d = ex_i;
    if (ex_i.f[FRAC_BITS-1]) begin
      ex_d.acc = prod[QW+FRAC_BITS-1:FRAC_BITS];
    end
    ex_d.f = {ex_i.f[FRAC_BITS-2:0], 1'b0};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ex_q <= ex_d;
    end
  end

  assign ex_o = ex_q;

endmodule

// ===== rtl/pm_dv_cell.sv =====
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step: brings down a dividend bit and yields one
// quotient bit.
// ----------------------------------------------------------------------------
module pm_dv_cell import pm_pkg::*; (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [PW-1:0] divisor_i,
  input  dv_t           dv_i,
  output dv_t           dv_o
);

  logic [PW:0] trial;
  logic [PW:0] diff;
  logic        ge;
  dv_t         dv_d;
  dv_t         dv_q;

  // Trial subtract, keep the remainder on a miss
  always_comb begin
    trial    = {dv_i.rem, dv_i.num[NW-1]};
    diff     = trial - {1'b0, divisor_i};
    ge       = (trial >= {1'b0, divisor_i});
    dv_d     = dv_i;
    dv_d.rem = ge ? diff[PW-1:0] : trial[PW-1:0];
    dv_d.num = {dv_i.num[NW-2:0], 1'b0};
    dv_d.quo = {dv_i.quo[NW-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv_q <= dv_d;
    end
  end

  assign dv_o = dv_q;

endmodule

// ===== rtl/polynomial_mutation.sv =====
// ----------------------------------------------------------------------------
// Polynomial mutation
// Applies polynomial mutation to one Q1.16 gene per item.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on the in channel (in_valid_i / in_stall_o) carrying a gene,
// two uniform draws and a last-gene mark; results leave on the out channel
// (out_valid_o / out_stall_i). Each item yields exactly one result.
// The datapath is a row of 96 register stages: cells for the first power
// (log2 chain, multiply, exp2 chain), the sum, a second log2 chain, a
// restoring divider chain for the root exponent and a second exp2 chain.
// One item is taken per cycle while in_stall_o is low. Every stage advances
// when the stage after it is empty or advancing, so bubbles close up and
// the block keeps taking items while a finished result waits; when
// out_stall_i holds, items pile up stage by stage and in_stall_o rises
// only once every stage is occupied.
// Reset empties all stages and loads the threshold (655) and eta (320).
// The user must write the config port (cfg_we_i, cfg_idx_i, cfg_data_i)
// only when the pipeline is empty (unenforced); unknown indexes are ignored.
// ----------------------------------------------------------------------------
module polynomial_mutation import pm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [QW-1:0]         gene_i,
  input  logic [15:0]           select_draw_i,
  input  logic [15:0]           step_draw_i,
  input  logic                  last_gene_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [QW-1:0]         new_gene_o,
  output logic                  was_mutated_o,
  output logic                  last_out_o
);

  localparam int LG1_0 = 1;
  localparam int P1    = LG1_0 + FRAC_BITS;
  localparam int EX1_0 = P1 + 1;
  localparam int MUL   = EX1_0 + FRAC_BITS;
  localparam int TN    = MUL + 1;
  localparam int LG2_0 = TN + 1;
  localparam int DVI   = LG2_0 + FRAC_BITS;
  localparam int DV_0  = DVI + 1;
  localparam int EXI   = DV_0 + NW;
  localparam int EX2_0 = EXI + 1;
  localparam int OUT   = EX2_0 + FRAC_BITS;
  localparam int NS    = OUT + 1;

  logic [THR_W-1:0]  thr_q;
  logic [DIST_W-1:0] dist_q;
  logic [NS-1:0]     v_q;
  logic [NS-1:0]     ld;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= THR_RESET;
      dist_q <= DIST_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_THRESHOLD: thr_q  <= cfg_data_i[THR_W-1:0];
        CFG_DIST:      dist_q <= cfg_data_i[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage advance: load when empty or when the content moves on
  assign ld[NS-1] = !v_q[NS-1] || !out_stall_i;
  for (genvar i = 0; i < NS-1; i++) begin : g_ld
    assign ld[i] = !v_q[i] || ld[i+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= (ld & {v_q[NS-2:0], in_valid_i}) | (~ld & v_q);
    end
  end

  assign in_stall_o  = !ld[0];
  assign out_valid_o = v_q[NS-1];

  // Front end: saturate, decide, pick the branch operands
  logic [QW-1:0] gene_sat;
  logic [QW-1:0] r17;
  logic [QW-1:0] r2;
  logic [QW-1:0] rc;
  logic [QW-1:0] x1;
  side_t         side_d;

  always_comb begin
    gene_sat      = (gene_i > ONE) ? ONE : gene_i;
    r17           = {1'b0, step_draw_i};
    r2            = {step_draw_i, 1'b0};
    rc            = ONE - r17;
    side_d.gene   = gene_sat;
    side_d.mut    = ({1'b0, select_draw_i} <= thr_q);
    side_d.last   = last_gene_i;
    side_d.branch = (r17 <= HALF);
    side_d.a      = side_d.branch ? r2 : {rc[QW-2:0], 1'b0};
    side_d.b      = side_d.branch ? (ONE - r2) : (r2 - ONE);
    side_d.p      = PW'(dist_q) + P_BIAS;
    x1            = side_d.branch ? (ONE - gene_sat) : gene_sat;
  end

  // Side line follows the cells stage by stage
  side_t side_q [NS];

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      side_q[0] <= side_d;
    end
    for (int i = 1; i < NS; i++) begin
      if (ld[i]) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // First power: log2 chain
  lg_t lg1_q;
  lg_t lg1_w [FRAC_BITS+1];

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      lg1_q <= lg_init(x1);
    end
  end

  assign lg1_w[0] = lg1_q;
  for (genvar j = 0; j < FRAC_BITS; j++) begin : g_lg1
    pm_lg_cell u_lg (
      .clk_i (clk_i),
      .en_i  (ld[LG1_0+j]),
      .lg_i  (lg1_w[j]),
      .lg_o  (lg1_w[j+1])
    );
  end

  // Scale the log by the exponent
  logic [LW-1:0]    l1;
  logic [LW+PW-1:0] p1_prod;
  ex_t              ex1_q;
  ex_t              ex1_w [FRAC_BITS+1];

  assign l1      = lg_lval(lg1_w[FRAC_BITS]);
  assign p1_prod = (LW+PW)'(l1) * (LW+PW)'(side_q[P1-1].p);

  always_ff @(posedge clk_i) begin
    if (ld[P1]) begin
      ex1_q <= ex_init(lg1_w[FRAC_BITS].zero, p1_prod[LW+PW-1:4]);
    end
  end

  assign ex1_w[0] = ex1_q;
  for (genvar j = 0; j < FRAC_BITS; j++) begin : g_ex1
    pm_ex_cell u_ex (
      .clk_i  (clk_i),
      .en_i   (ld[EX1_0+j]),
      .coef_i (exp_coef(j)),
      .ex_i   (ex1_w[j]),
      .ex_o   (ex1_w[j+1])
    );
  end

  // Weight the power
  logic [QW-1:0]   pw1;
  logic [2*QW-1:0] mul_q;

  assign pw1 = ex_val(ex1_w[FRAC_BITS]);

  always_ff @(posedge clk_i) begin
    if (ld[MUL]) begin
      mul_q <= (2*QW)'(side_q[MUL-1].b) * (2*QW)'(pw1);
    end
  end

  // Form t, clamp to one, normalize for the root
  logic [QW+1:0] t_sum;
  logic [QW-1:0] t_val;
  lg_t           lg2_q;
  lg_t           lg2_w [FRAC_BITS+1];

  assign t_sum = (QW+2)'(side_q[TN-1].a) + (QW+2)'(mul_q[2*QW-1:FRAC_BITS]);
  assign t_val = (t_sum > (QW+2)'(ONE)) ? ONE : t_sum[QW-1:0];

  always_ff @(posedge clk_i) begin
    if (ld[TN]) begin
      lg2_q <= lg_init(t_val);
    end
  end

  assign lg2_w[0] = lg2_q;
  for (genvar j = 0; j < FRAC_BITS; j++) begin : g_lg2
    pm_lg_cell u_lg (
      .clk_i (clk_i),
      .en_i  (ld[LG2_0+j]),
      .lg_i  (lg2_w[j]),
      .lg_o  (lg2_w[j+1])
    );
  end

  // Root exponent: divide the log by the exponent
  logic [LW-1:0] l2;
  dv_t           dv_q;
  dv_t           dv_w [NW+1];

  assign l2 = lg_lval(lg2_w[FRAC_BITS]);

  always_ff @(posedge clk_i) begin
    if (ld[DVI]) begin
      dv_q.num  <= {l2, 4'b0000};
      dv_q.rem  <= '0;
      dv_q.quo  <= '0;
      dv_q.zero <= lg2_w[FRAC_BITS].zero;
    end
  end

  assign dv_w[0] = dv_q;
  for (genvar j = 0; j < NW; j++) begin : g_dv
    pm_dv_cell u_dv (
      .clk_i     (clk_i),
      .en_i      (ld[DV_0+j]),
      .divisor_i (side_q[DV_0+j-1].p),
      .dv_i      (dv_w[j]),
      .dv_o      (dv_w[j+1])
    );
  end

  // Root: exp2 chain
  ex_t ex2_q;
  ex_t ex2_w [FRAC_BITS+1];

  always_ff @(posedge clk_i) begin
    if (ld[EXI]) begin
      ex2_q <= ex_init(dv_w[NW].zero, PV'(dv_w[NW].quo));
    end
  end

  assign ex2_w[0] = ex2_q;
  for (genvar j = 0; j < FRAC_BITS; j++) begin : g_ex2
    pm_ex_cell u_ex (
      .clk_i  (clk_i),
      .en_i   (ld[EX2_0+j]),
      .coef_i (exp_coef(j)),
      .ex_i   (ex2_w[j]),
      .ex_o   (ex2_w[j+1])
    );
  end

  // Apply the step and clamp to [0, 1]
  side_t         sd;
  logic [QW-1:0] root;
  logic [QW:0]   s_lo;
  logic [QW:0]   ny;
  logic [QW-1:0] ny_c;
  logic [QW-1:0] res_gene;

  always_comb begin
    sd   = side_q[OUT-1];
    root = ex_val(ex2_w[FRAC_BITS]);
    s_lo = (QW+1)'(sd.gene) + (QW+1)'(root);
    if (sd.branch) begin
      ny = (s_lo >= (QW+1)'(ONE)) ? (s_lo - (QW+1)'(ONE)) : '0;
    end else begin
      ny = (QW+1)'(sd.gene) + (QW+1)'(ONE - root);
    end
    ny_c     = (ny > (QW+1)'(ONE)) ? ONE : ny[QW-1:0];
    res_gene = sd.mut ? ny_c : sd.gene;
  end

  // Output register
  logic [QW-1:0] new_gene_q;
  logic          mut_q;
  logic          last_q;

  always_ff @(posedge clk_i) begin
    if (ld[OUT]) begin
      new_gene_q <= res_gene;
      mut_q      <= sd.mut;
      last_q     <= sd.last;
    end
  end

  assign new_gene_o    = new_gene_q;
  assign was_mutated_o = mut_q;
  assign last_out_o    = last_q;

  // Checks
  a_gene_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (new_gene_o <= ONE))
    else $error("result gene above one");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result dropped");

  a_accept_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v_q[0])
    else $error("accepted item not in first stage");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v_q[0] && out_valid_o && out_stall_i))
    else $error("input stalled while pipeline can move");

endmodule
